>>> rtl/assert_macros.svh
// Assertion helpers shared by the tracker RTL.
// Each one samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Consequence must hold in the same cycle as the trigger.
`define CRT_ASSERT_IMP(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/crt_pkg.sv
`timescale 1ns / 1ps

package crt_pkg;

  // Table and packet limits
  localparam int unsigned FrameSlots = 8;
  localparam int unsigned MaxChunks  = 64;
  localparam int unsigned MaxPacket  = 1500;
  localparam int unsigned HdrBytes   = 8;
  localparam int unsigned QueueDepth = 2;

  // Fixed field widths
  localparam int unsigned FrameW   = 16;
  localparam int unsigned ChunkW   = 16;
  localparam int unsigned CountInW = 16;
  localparam int unsigned PayW     = 16;
  localparam int unsigned PlenW    = 11;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned BytesW   = 17;
  localparam int unsigned HeldW    = 7;

  // Derived widths
  localparam int unsigned SlotIdxW  = (FrameSlots > 1) ? $clog2(FrameSlots) : 1;
  localparam int unsigned ChunkIdxW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int unsigned CountW    = $clog2(MaxChunks + 1);
  localparam int unsigned QPtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  // Result status codes
  typedef logic [StatusW-1:0] status_t;
  localparam status_t StOk    = 3'd0;
  localparam status_t StDup   = 3'd1;
  localparam status_t StRange = 3'd2;
  localparam status_t StBad   = 3'd3;
  localparam status_t StFull  = 3'd4;
  localparam status_t StMany  = 3'd5;

  // Classified item, as handed from the front to the back
  typedef struct packed {
    logic                 bad;        // malformed length fields
    logic                 too_many;   // chunk count above the table limit
    logic                 empty;      // chunk count of zero
    logic                 chunk_over; // chunk number beyond any bitmap
    logic [FrameW-1:0]    frame;
    logic [ChunkIdxW-1:0] chunk_lo;
    logic [CountW-1:0]    count;
    logic [PayW-1:0]      pay;
  } crt_item_t;

  typedef struct packed {
    logic      valid;
    crt_item_t item;
  } crt_push_t;

endpackage

>>> rtl/crt_intf.sv
`timescale 1ns / 1ps

// Chunk header channel
interface crt_in_if;
  import crt_pkg::*;
  logic                valid;
  logic                ready;
  logic [FrameW-1:0]   frame_number;
  logic [ChunkW-1:0]   chunk_number;
  logic [CountInW-1:0] chunk_count;
  logic [PayW-1:0]     payload_bytes;
  logic [PlenW-1:0]    packet_bytes;

  modport source (output valid, frame_number, chunk_number, chunk_count,
                  payload_bytes, packet_bytes, input ready);
  modport sink (input valid, frame_number, chunk_number, chunk_count,
                payload_bytes, packet_bytes, output ready);
endinterface

// Per-packet result channel
interface crt_out_if;
  import crt_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic               frame_done;
  logic [FrameW-1:0]  done_frame;
  logic [BytesW-1:0]  done_bytes;
  logic [HeldW-1:0]   chunks_held;

  modport source (output valid, status, frame_done, done_frame, done_bytes,
                  chunks_held, input ready);
  modport sink (input valid, status, frame_done, done_frame, done_bytes,
                chunks_held, output ready);
endinterface

>>> rtl/crt_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Small FIFO between the classifier and the table engine
module crt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crt_pkg::crt_push_t  push_i,
  output logic                full_o,
  output logic                valid_o,
  output crt_pkg::crt_item_t  item_o,
  input  logic                pop_i
);
  import crt_pkg::*;

  crt_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `CRT_ASSERT(q_cnt_bound, cnt_q <= QCntW'(QueueDepth))
  `CRT_ASSERT_IMP(q_full_holds, full_o && !do_pop, ##1 (cnt_q == QCntW'(QueueDepth)))

endmodule

>>> rtl/crt_front.sv
`timescale 1ns / 1ps

// Front end: accepts chunk headers and classifies them
module crt_front (
  crt_in_if.sink             in_i,
  input  logic               full_i,
  output crt_pkg::crt_push_t push_o
);
  import crt_pkg::*;

  logic short_pkt, long_pkt, pay_big;

  // length sanity: header present, packet not oversize, payload fits
  assign short_pkt = in_i.packet_bytes < PlenW'(HdrBytes);
  assign long_pkt  = 32'(in_i.packet_bytes) > 32'(MaxPacket);
  assign pay_big   = ((PayW + 1)'(in_i.payload_bytes) + (PayW + 1)'(HdrBytes))
                     > (PayW + 1)'(in_i.packet_bytes);

  assign in_i.ready = !full_i;

  // classified item toward the queue
  always_comb begin
    push_o.valid           = in_i.valid;
    push_o.item.bad        = short_pkt || long_pkt || pay_big;
    push_o.item.too_many   = 32'(in_i.chunk_count) > 32'(MaxChunks);
    push_o.item.empty      = (in_i.chunk_count == '0);
    push_o.item.chunk_over = 32'(in_i.chunk_number) >= 32'(MaxChunks);
    push_o.item.frame      = in_i.frame_number;
    push_o.item.chunk_lo   = in_i.chunk_number[ChunkIdxW-1:0];
    push_o.item.count      = in_i.chunk_count[CountW-1:0];
    push_o.item.pay        = in_i.payload_bytes;
  end

endmodule

>>> rtl/crt_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Back end: frame table lookup, update and result register
module crt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  crt_pkg::crt_item_t item_i,
  output logic               pop_o,
  crt_out_if.source          out_o
);
  import crt_pkg::*;

  // frame table
  logic [FrameSlots-1:0] valid_q;
  logic [FrameW-1:0]     tag_q   [FrameSlots];
  logic [CountW-1:0]     total_q [FrameSlots];
  logic [CountW-1:0]     held_q  [FrameSlots];
  logic [MaxChunks-1:0]  map_q   [FrameSlots];
  logic [BytesW-1:0]     bytes_q [FrameSlots];

  // result register
  logic                out_valid_q;
  status_t             out_status_q;
  logic                out_done_q;
  logic [FrameW-1:0]   out_frame_q;
  logic [BytesW-1:0]   out_bytes_q;
  logic [CountW-1:0]   out_held_q;

  logic                hit_any, free_any;
  logic [SlotIdxW-1:0] hit_idx, free_idx, sel;
  logic [CountW-1:0]   cur_total, cur_held, new_held, res_held;
  logic [MaxChunks-1:0] cur_map, bit_mask;
  logic [BytesW-1:0]   cur_bytes, new_bytes, res_bytes;
  logic [BytesW:0]     sum;
  logic                in_range, dup, acc, wr_slot, res_done;
  status_t             res_status;

  assign pop_o = valid_i && (!out_valid_q || out_o.ready);

  // tag match and free slot search, lowest slot wins
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = FrameSlots - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == item_i.frame)) begin
        hit_any = 1'b1;
        hit_idx = SlotIdxW'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotIdxW'(i);
      end
    end
  end

  // current entry: the hit slot, or a fresh one when opening
  assign sel       = hit_any ? hit_idx : free_idx;
  assign cur_total = hit_any ? total_q[hit_idx] : item_i.count;
  assign cur_held  = hit_any ? held_q[hit_idx] : '0;
  assign cur_map   = hit_any ? map_q[hit_idx] : '0;
  assign cur_bytes = hit_any ? bytes_q[hit_idx] : '0;

  assign bit_mask  = MaxChunks'(1) << item_i.chunk_lo;
  assign in_range  = !item_i.chunk_over && (CountW'(item_i.chunk_lo) < cur_total);
  assign dup       = cur_map[item_i.chunk_lo];
  assign sum       = {1'b0, cur_bytes} + (BytesW + 1)'(item_i.pay);
  assign new_bytes = sum[BytesW] ? '1 : sum[BytesW-1:0];
  assign new_held  = cur_held + 1'b1;

  // classify against the table
  always_comb begin
    res_status = StOk;
    res_done   = 1'b0;
    res_bytes  = '0;
    res_held   = '0;
    acc        = 1'b0;
    wr_slot    = 1'b0;
    if (item_i.bad) begin
      res_status = StBad;
    end else if (!hit_any && item_i.too_many) begin
      res_status = StMany;
    end else if (!hit_any && item_i.empty) begin
      res_done = 1'b1;
    end else if (!hit_any && !free_any) begin
      res_status = StFull;
    end else begin
      // a new frame opens its slot even when the chunk is rejected
      wr_slot = !hit_any;
      if (!in_range) begin
        res_status = StRange;
        res_bytes  = cur_bytes;
        res_held   = cur_held;
      end else if (dup) begin
        res_status = StDup;
        res_bytes  = cur_bytes;
        res_held   = cur_held;
      end else begin
        acc       = 1'b1;
        wr_slot   = 1'b1;
        res_bytes = new_bytes;
        res_held  = new_held;
        res_done  = (new_held == cur_total);
      end
    end
  end

  // slot contents
  always_ff @(posedge clk_i) begin
    if (pop_o && wr_slot) begin
      tag_q[sel]   <= item_i.frame;
      total_q[sel] <= cur_total;
      held_q[sel]  <= acc ? new_held : cur_held;
      map_q[sel]   <= acc ? (cur_map | bit_mask) : cur_map;
      bytes_q[sel] <= acc ? new_bytes : cur_bytes;
    end
  end

  // slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pop_o && wr_slot) begin
      valid_q[sel] <= !res_done;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_status_q <= res_status;
      out_done_q   <= res_done;
      out_frame_q  <= item_i.frame;
      out_bytes_q  <= res_bytes;
      out_held_q   <= res_held;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.frame_done  = out_done_q;
  assign out_o.done_frame  = out_frame_q;
  assign out_o.done_bytes  = out_bytes_q;
  assign out_o.chunks_held = HeldW'(out_held_q);

  `CRT_ASSERT_IMP(bk_done_is_ok, out_valid_q && out_done_q, out_status_q == StOk)
  `CRT_ASSERT_IMP(bk_drop_no_entry,
      out_valid_q && (out_status_q == StBad || out_status_q == StFull ||
                      out_status_q == StMany),
      out_bytes_q == '0 && out_held_q == '0)
  `CRT_ASSERT_IMP(bk_table_idle, !pop_o, ##1 (valid_q == $past(valid_q)))

endmodule

>>> rtl/chunk_reassembly_tracker.sv
// A header is written into the queue, and its result is then registered in the result register.
// Throughput: one header per cycle while the result side accepts; the table is looked up and updated on pop.
// The front classifies, a two-entry queue decouples it from the table engine.
// A stalled result register holds its item; the queue takes input until it is full.
// Reset (rst_ni low, asynchronous) empties the queue, the result register and
// marks every table slot free; no clearing pass is needed.
`timescale 1ns / 1ps

module chunk_reassembly_tracker (
  input  logic      clk_i,
  input  logic      rst_ni,
  crt_in_if.sink    in_i,
  crt_out_if.source out_o
);
  import crt_pkg::*;

  crt_push_t push;
  crt_item_t q_item;
  logic      q_full, q_valid, q_pop;

  crt_front u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push)
  );

  crt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  crt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (q_item),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

>>> bench/tb_chunk_reassembly_tracker.sv
`timescale 1ns / 1ps

module tb_chunk_reassembly_tracker;
  import crt_pkg::*;

  // One chunk header as driven on the input channel
  typedef struct packed {
    logic [FrameW-1:0]   frame_number;
    logic [ChunkW-1:0]   chunk_number;
    logic [CountInW-1:0] chunk_count;
    logic [PayW-1:0]     payload_bytes;
    logic [PlenW-1:0]    packet_bytes;
  } chunk_hdr_t;

  // One per-packet verdict as seen on the result channel
  typedef struct packed {
    status_t           status;
    logic              frame_done;
    logic [FrameW-1:0] done_frame;
    logic [BytesW-1:0] done_bytes;
    logic [HeldW-1:0]  chunks_held;
  } chunk_result_t;

  // Shadow of the open-frame table plus the queue of verdicts still due
  class frame_table_board;
    bit                 is_open       [FrameSlots];
    bit [FrameW-1:0]    frame_tag     [FrameSlots];
    bit [HeldW-1:0]     chunks_needed [FrameSlots];
    bit [HeldW-1:0]     chunks_got    [FrameSlots];
    bit [MaxChunks-1:0] got_map       [FrameSlots];
    bit [BytesW-1:0]    byte_sum      [FrameSlots];
    chunk_result_t      due_q[$];
    int                 mismatches;
    int                 checked;

    // Work out the verdict for an accepted header and update the table
    function void note_header(chunk_hdr_t h);
      chunk_result_t    r;
      int               hit;
      int               free_at;
      logic [BytesW:0]  sum;
      r            = '0;
      r.status     = StOk;
      r.done_frame = h.frame_number;
      hit          = -1;
      free_at      = -1;
      if (h.packet_bytes < HdrBytes || h.packet_bytes > MaxPacket ||
          h.payload_bytes > h.packet_bytes - HdrBytes) begin
        r.status = StBad;
      end else begin
        // first matching tag, first free slot
        for (int i = 0; i < FrameSlots; i++) begin
          if (is_open[i]) begin
            if (hit < 0 && frame_tag[i] == h.frame_number) hit = i;
          end else if (free_at < 0) begin
            free_at = i;
          end
        end
        if (hit < 0) begin
          if (h.chunk_count > MaxChunks) begin
            r.status = StMany;
          end else if (h.chunk_count == 0) begin
            r.frame_done = 1'b1;
          end else if (free_at < 0) begin
            r.status = StFull;
          end else begin
            hit                = free_at;
            is_open[hit]       = 1'b1;
            frame_tag[hit]     = h.frame_number;
            chunks_needed[hit] = h.chunk_count[HeldW-1:0];
            chunks_got[hit]    = '0;
            got_map[hit]       = '0;
            byte_sum[hit]      = '0;
          end
        end
        if (hit >= 0) begin
          if (h.chunk_number >= chunks_needed[hit]) begin
            r.status = StRange;
          end else if (got_map[hit][h.chunk_number[ChunkIdxW-1:0]]) begin
            r.status = StDup;
          end else begin
            got_map[hit][h.chunk_number[ChunkIdxW-1:0]] = 1'b1;
            chunks_got[hit] = chunks_got[hit] + 1'b1;
            sum = {1'b0, byte_sum[hit]} + (BytesW + 1)'(h.payload_bytes);
            byte_sum[hit] = (sum > {BytesW{1'b1}}) ? {BytesW{1'b1}} : sum[BytesW-1:0];
            // last missing chunk frees the slot
            if (chunks_got[hit] == chunks_needed[hit]) begin
              is_open[hit] = 1'b0;
              r.frame_done = 1'b1;
            end
          end
          r.done_bytes  = byte_sum[hit];
          r.chunks_held = chunks_got[hit];
        end
      end
      due_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      mismatches++;
      $display("MISMATCH at result %0d, %s: got %0h, want %0h", checked, what, got_v,
               want_v);
    endtask

    // Compare one accepted verdict with the oldest one due
    task check_result(status_t st, logic fd, logic [FrameW-1:0] fr,
                      logic [BytesW-1:0] by, logic [HeldW-1:0] hd);
      chunk_result_t want;
      checked++;
      if (due_q.size() == 0) begin
        report_mismatch("result with nothing due, frame", 32'(fr), '0);
        return;
      end
      want = due_q.pop_front();
      if (st !== want.status) report_mismatch("status", 32'(st), 32'(want.status));
      if (fd !== want.frame_done)
        report_mismatch("frame_done", 32'(fd), 32'(want.frame_done));
      if (fr !== want.done_frame)
        report_mismatch("done_frame", 32'(fr), 32'(want.done_frame));
      if (by !== want.done_bytes)
        report_mismatch("done_bytes", 32'(by), 32'(want.done_bytes));
      if (hd !== want.chunks_held)
        report_mismatch("chunks_held", 32'(hd), 32'(want.chunks_held));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   sink_stall_pct;

  frame_table_board board;

  crt_in_if  in_if();
  crt_out_if out_if();

  chunk_reassembly_tracker uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Known values on every input from time zero
  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    src_idle_pct         = 0;
    sink_stall_pct       = 0;
    in_if.valid          = 1'b0;
    in_if.frame_number   = '0;
    in_if.chunk_number   = '0;
    in_if.chunk_count    = '0;
    in_if.payload_bytes  = '0;
    in_if.packet_bytes   = '0;
    out_if.ready         = 1'b0;
  end

  // Result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        board.check_result(out_if.status, out_if.frame_done, out_if.done_frame,
                           out_if.done_bytes, out_if.chunks_held);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Header with legal random sizes around the given ids
  function automatic chunk_hdr_t sized(logic [FrameW-1:0] f, logic [ChunkW-1:0] c,
                                       logic [CountInW-1:0] n);
    chunk_hdr_t  h;
    int unsigned room;
    h.frame_number = f;
    h.chunk_number = c;
    h.chunk_count  = n;
    case ($urandom_range(7))
      0:       h.packet_bytes = PlenW'(HdrBytes);
      1:       h.packet_bytes = PlenW'(MaxPacket);
      default: h.packet_bytes = PlenW'($urandom_range(MaxPacket, HdrBytes));
    endcase
    room = h.packet_bytes - HdrBytes;
    case ($urandom_range(5))
      0:       h.payload_bytes = '0;
      1:       h.payload_bytes = PayW'(room);
      default: h.payload_bytes = PayW'($urandom_range(room, 0));
    endcase
    return h;
  endfunction

  // Drive one header and wait for it to be taken
  task automatic send_header(input chunk_hdr_t h);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.frame_number  <= h.frame_number;
    in_if.chunk_number  <= h.chunk_number;
    in_if.chunk_count   <= h.chunk_count;
    in_if.payload_bytes <= h.payload_bytes;
    in_if.packet_bytes  <= h.packet_bytes;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    board.note_header(h);
  endtask

  // Sender holds off until every verdict is back
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk_i);
  endtask

  // Random traffic, mostly chunks of frames that are already open
  task automatic run_random(int num, int src_pct, int sink_pct);
    chunk_hdr_t          h;
    int                  slot;
    int                  pick;
    int                  first;
    logic [ChunkW-1:0]   c;
    logic [CountInW-1:0] cnt;
    logic [FrameW-1:0]   f;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (num) begin
      pick  = $urandom_range(99);
      slot  = -1;
      first = $urandom_range(FrameSlots - 1);
      for (int k = 0; k < FrameSlots; k++)
        if (slot < 0 && board.is_open[(first + k) % FrameSlots]) slot = (first + k) % FrameSlots;
      if (pick < 60 && slot >= 0) begin
        // chunk of an open frame: missing, repeated or past the end
        c = ChunkW'($urandom_range(board.chunks_needed[slot] - 1));
        if (pick < 48) begin
          while (board.got_map[slot][c[ChunkIdxW-1:0]]) c = (c + 1) % board.chunks_needed[slot];
        end else if (pick >= 54) begin
          c = ($urandom_range(3) == 0) ? 16'hFFFF :
              ChunkW'(board.chunks_needed[slot] + $urandom_range(3));
        end
        h = sized(board.frame_tag[slot], c, CountInW'($urandom));
      end else if (pick < 85) begin
        // new frame, mostly short
        case ($urandom_range(19))
          0:       cnt = '0;
          1:       cnt = CountInW'($urandom_range(16'hFFFF, MaxChunks + 1));
          2, 3:    cnt = CountInW'($urandom_range(MaxChunks, 17));
          default: cnt = CountInW'($urandom_range(8, 1));
        endcase
        f = ($urandom_range(3) == 0) ? FrameW'($urandom_range(15)) : FrameW'($urandom);
        c = (cnt != 0 && $urandom_range(7) != 0) ? ChunkW'($urandom_range(cnt - 1)) :
                                                   ChunkW'($urandom);
        h = sized(f, c, cnt);
      end else if (pick < 93) begin
        // malformed lengths
        h = sized(FrameW'($urandom_range(15)), ChunkW'($urandom_range(7)),
                  CountInW'($urandom_range(8, 1)));
        case ($urandom_range(2))
          0: h.packet_bytes = PlenW'($urandom_range(HdrBytes - 1));
          1: h.packet_bytes = PlenW'($urandom_range(11'h7FF, MaxPacket + 1));
          default: h.payload_bytes =
              PayW'($urandom_range(16'hFFFF, h.packet_bytes - HdrBytes + 1));
        endcase
      end else begin
        // raw noise on every field
        h.frame_number  = FrameW'($urandom);
        h.chunk_number  = ChunkW'($urandom);
        h.chunk_count   = CountInW'($urandom);
        h.payload_bytes = PayW'($urandom);
        h.packet_bytes  = PlenW'($urandom_range(11'h7FF));
      end
      send_header(h);
    end
  endtask

  // Main sequence
  initial begin
    chunk_hdr_t h;
    board = new;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // length checks
    h = sized(16'h0001, 16'd0, 16'd1);
    h.packet_bytes = 11'd0;
    send_header(h);
    h.packet_bytes = 11'd7;
    send_header(h);
    h.packet_bytes = 11'd1501;
    send_header(h);
    h.packet_bytes = 11'h7FF;
    send_header(h);
    h.packet_bytes  = 11'd1500;
    h.payload_bytes = 16'd1493;
    send_header(h);
    h.payload_bytes = 16'hFFFF;
    send_header(h);

    // chunk count above the table limit, then an empty frame
    h = sized(16'h0002, 16'd0, 16'd65);
    send_header(h);
    h.chunk_count  = 16'hFFFF;
    h.chunk_number = 16'hFFFF;
    send_header(h);
    send_header(sized(16'h0003, 16'd5, 16'd0));

    // single-chunk frame with the largest payload
    h = sized(16'h0000, 16'd0, 16'd1);
    h.packet_bytes  = 11'd1500;
    h.payload_bytes = 16'd1492;
    send_header(h);

    // widest frame: last chunk empty, its repeat, past the end, count ignored
    h = sized(16'hFFFF, 16'd63, 16'd64);
    h.packet_bytes  = 11'd8;
    h.payload_bytes = '0;
    send_header(h);
    send_header(h);
    send_header(sized(16'hFFFF, 16'd64, 16'd3));
    send_header(sized(16'hFFFF, 16'hFFFF, 16'd3));
    send_header(sized(16'hFFFF, 16'd0, 16'd9));

    // chunk past the end on a frame it just opened
    send_header(sized(16'h1234, 16'd7, 16'd2));

    // fill the table, then one more new frame
    for (int k = 0; k < FrameSlots - 2; k++)
      send_header(sized(FrameW'(16'h0100 + k), 16'd0, 16'd2));
    send_header(sized(16'h0200, 16'd0, 16'd1));
    wait_drain();

    run_random(400, 0, 0);
    wait_drain();
    run_random(380, 59, 0);
    wait_drain();
    run_random(380, 0, 59);
    wait_drain();
    run_random(380, 28, 28);
    wait_drain();

    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0 && board.due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
